### hdl/upd_pkg.sv
package upd_pkg;

  localparam int unsigned CFG_W       = 18;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned DIST_W      = 12;
  localparam int unsigned THRESH_W    = 12;
  localparam int unsigned LEVEL_W     = 5;
  localparam int unsigned WAIT_W      = 18;
  localparam int unsigned PULSE_W     = 14;
  localparam int unsigned GAP_W       = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_NEAR_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENTER_COUNT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEAVE_COUNT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ECHO_WAIT      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ECHO_WIDTH     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_GAP            = 3'd5;

  localparam logic [DIST_W-1:0] TIMEOUT_CM = 12'd3000;
  localparam logic [WAIT_W-1:0] TRIG_LOW_TICKS  = 18'd2;
  localparam logic [WAIT_W-1:0] TRIG_HIGH_TICKS = 18'd5;

  // width / 58 as (width * ceil(2^20 / 58)) >> 20, exact for 14-bit widths
  localparam int unsigned DIV_SHIFT  = 20;
  localparam int unsigned DIV_MULT_W = 15;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT = 15'd18079;
  localparam int unsigned PROD_W = PULSE_W + DIV_MULT_W;

  typedef struct packed {
    logic [WAIT_W-1:0]  wait_limit;
    logic [PULSE_W-1:0] width_limit;
    logic [GAP_W-1:0]   gap;
  } upd_timing_t;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] distance;
  } upd_sample_t;

endpackage

### hdl/ultrasonic_presence_detector.sv
// Ultrasonic presence detector. Each echo transaction is one microsecond tick of the
// sampled echo pin and yields exactly one result transaction on the next cycle; the block
// takes one tick per clock cycle when echo_stall is low; its output register holds the result
// while the far side stalls. The block runs its own ranging cycles (trigger low 2 ticks,
// high 5, wait for the echo rise, measure the high width, idle for the gap) and reports a
// distance of width/58 cm, or 3000 cm when the echo never rose. Each distance enters a
// chain of WINDOW_DEPTH one-bit cells as near or not near; presence sets when the near
// count exceeds enter_count and clears when it falls below leave_count. After reset the
// window is all not near, presence is 1 and distance_cm reads 0 until the first sample.
module ultrasonic_presence_detector #(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [upd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [upd_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              echo_valid,
  output logic                              echo_stall,
  input  logic                              echo_level,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              trigger_level,
  output logic                              sample_valid,
  output logic [upd_pkg::DIST_W-1:0]        distance_cm,
  output logic                              present
);

  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > upd_pkg::LEVEL_W) ? CNT_W : upd_pkg::LEVEL_W;

  logic [upd_pkg::THRESH_W-1:0] near_threshold_cm;
  logic [upd_pkg::LEVEL_W-1:0]  enter_count;
  logic [upd_pkg::LEVEL_W-1:0]  leave_count;
  upd_pkg::upd_timing_t         timing;
  upd_pkg::upd_sample_t         sample;

  logic                    accept, trigger, is_near, shift;
  logic [WINDOW_DEPTH-1:0] window;
  logic [CNT_W-1:0]        near_count, near_count_next;
  logic                    present_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_threshold_cm  <= upd_pkg::THRESH_W'(50);
      enter_count        <= upd_pkg::LEVEL_W'(8);
      leave_count        <= upd_pkg::LEVEL_W'(4);
      timing.wait_limit  <= upd_pkg::WAIT_W'(200000);
      timing.width_limit <= upd_pkg::PULSE_W'(10000);
      timing.gap         <= upd_pkg::GAP_W'(1000);
    end else if (cfg_write) begin
      case (cfg_index)
        upd_pkg::REG_NEAR_THRESHOLD: near_threshold_cm <= cfg_data[upd_pkg::THRESH_W-1:0];
        upd_pkg::REG_ENTER_COUNT:    enter_count <= cfg_data[upd_pkg::LEVEL_W-1:0];
        upd_pkg::REG_LEAVE_COUNT:    leave_count <= cfg_data[upd_pkg::LEVEL_W-1:0];
        upd_pkg::REG_ECHO_WAIT:      timing.wait_limit <= cfg_data[upd_pkg::WAIT_W-1:0];
        upd_pkg::REG_ECHO_WIDTH:     timing.width_limit <= cfg_data[upd_pkg::PULSE_W-1:0];
        upd_pkg::REG_GAP:            timing.gap <= cfg_data[upd_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign echo_stall = result_valid & result_stall;
  assign accept     = echo_valid & ~echo_stall;

  upd_ranger u_ranger (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .echo    (echo_level),
    .timing  (timing),
    .trigger (trigger),
    .sample  (sample)
  );

  assign is_near = (sample.distance < near_threshold_cm);
  assign shift   = accept & sample.valid;

  genvar i;
  generate
    for (i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      upd_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     ((i == 0) ? is_near : window[(i == 0) ? 0 : i - 1]),
        .q     (window[i])
      );
    end
  endgenerate

  assign near_count_next = near_count - CNT_W'(window[WINDOW_DEPTH-1]) + CNT_W'(is_near);

  always_comb begin
    present_next = present;
    if (CMP_W'(near_count_next) > CMP_W'(enter_count)) begin
      present_next = 1'b1;
    end else if (CMP_W'(near_count_next) < CMP_W'(leave_count)) begin
      present_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      near_count   <= '0;
      present      <= 1'b1;
      distance_cm  <= '0;
    end else begin
      if (accept) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (shift) begin
        near_count  <= near_count_next;
        present     <= present_next;
        distance_cm <= sample.distance;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      trigger_level <= trigger;
      sample_valid  <= sample.valid;
    end
  end

endmodule

### hdl/upd_cell.sv
module upd_cell (
  input  logic clk,
  input  logic rst,
  input  logic shift,
  input  logic d,
  output logic q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= 1'b0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

### hdl/upd_ranger.sv
module upd_ranger (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                echo,
  input  upd_pkg::upd_timing_t timing,
  output logic                trigger,
  output upd_pkg::upd_sample_t sample
);

  localparam logic [2:0] PH_TRIG_LOW  = 3'd0;
  localparam logic [2:0] PH_TRIG_HIGH = 3'd1;
  localparam logic [2:0] PH_WAIT_RISE = 3'd2;
  localparam logic [2:0] PH_MEASURE   = 3'd3;
  localparam logic [2:0] PH_GAP       = 3'd4;

  logic [2:0]                    phase, phase_next;
  logic [upd_pkg::WAIT_W-1:0]    timer, timer_next, timer_inc;
  logic [upd_pkg::PULSE_W-1:0]   width, width_next, width_inc, width_sel;
  logic                          finish, timeout;
  logic [upd_pkg::PROD_W-1:0]    prod;
  logic [upd_pkg::DIST_W-1:0]    quotient;

  assign timer_inc = timer + 1'b1;
  assign width_inc = (width < timing.width_limit) ? width + 1'b1 : width;
  assign prod      = upd_pkg::PROD_W'(width_sel) * upd_pkg::PROD_W'(upd_pkg::DIV_MULT);
  assign quotient  = upd_pkg::DIST_W'(prod[upd_pkg::PROD_W-1:upd_pkg::DIV_SHIFT]);

  always_comb begin
    phase_next = phase;
    timer_next = timer;
    width_next = width;
    width_sel  = width;
    trigger    = 1'b0;
    finish     = 1'b0;
    timeout    = 1'b0;
    case (phase)
      PH_TRIG_HIGH: begin
        trigger = 1'b1;
        timer_next = timer_inc;
        if (timer_inc >= upd_pkg::TRIG_HIGH_TICKS) begin
          phase_next = PH_WAIT_RISE;
          timer_next = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (echo) begin
          phase_next = PH_MEASURE;
          timer_next = '0;
          width_next = upd_pkg::PULSE_W'(1);
          width_sel  = upd_pkg::PULSE_W'(1);
          finish     = (upd_pkg::PULSE_W'(1) >= timing.width_limit);
        end else begin
          timer_next = timer_inc;
          finish     = (timer_inc >= timing.wait_limit);
          timeout    = finish;
        end
      end
      PH_MEASURE: begin
        if (echo) begin
          width_next = width_inc;
          width_sel  = width_inc;
          finish     = (width_inc >= timing.width_limit);
        end else begin
          finish = 1'b1;
        end
      end
      PH_GAP: begin
        timer_next = timer_inc;
        if (timer_inc >= upd_pkg::WAIT_W'(timing.gap)) begin
          phase_next = PH_TRIG_LOW;
          timer_next = '0;
        end
      end
      default: begin
        phase_next = PH_TRIG_LOW;
        timer_next = timer_inc;
        if (timer_inc >= upd_pkg::TRIG_LOW_TICKS) begin
          phase_next = PH_TRIG_HIGH;
          timer_next = '0;
        end
      end
    endcase
    if (finish) begin
      width_next = '0;
      timer_next = '0;
      phase_next = (timing.gap == '0) ? PH_TRIG_LOW : PH_GAP;
    end
  end

  assign sample.valid    = finish;
  assign sample.distance = timeout ? upd_pkg::TIMEOUT_CM : quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TRIG_LOW;
      timer <= '0;
      width <= '0;
    end else if (advance) begin
      phase <= phase_next;
      timer <= timer_next;
      width <= width_next;
    end
  end

endmodule

### hdl/upd_checker.sv
module upd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       result_valid,
  input logic                       result_stall,
  input logic                       trigger_level,
  input logic                       sample_valid,
  input logic [upd_pkg::DIST_W-1:0] distance_cm,
  input logic                       present
);

  a_no_trigger_on_sample: assert property (@(posedge clk) disable iff (rst)
    result_valid && sample_valid |-> !trigger_level)
    else $error("trigger high on a sample transaction");

  a_distance_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> distance_cm <= upd_pkg::TIMEOUT_CM)
    else $error("distance out of range");

  a_distance_held: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !(result_valid && sample_valid) |-> $stable(distance_cm))
    else $error("distance changed without a sample");

  a_present_held: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !(result_valid && sample_valid) |-> $stable(present))
    else $error("presence changed without a sample");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(distance_cm))
    else $error("stalled result dropped");

endmodule

bind ultrasonic_presence_detector upd_checker u_upd_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .trigger_level (trigger_level),
  .sample_valid  (sample_valid),
  .distance_cm   (distance_cm),
  .present       (present)
);
